>>> rtl/frwm_pkg.sv
`default_nettype none
package frwm_pkg;
    localparam int WindowDepth = 4096;
    localparam int PtrW  = $clog2(WindowDepth);
    localparam int CntW  = PtrW + 1;
    localparam int RateW = 10;
    localparam int TimeW = 32;
    localparam int SumW  = RateW + CntW;
    localparam int EntW  = RateW + TimeW;
    localparam int BinW  = 4;
    localparam int BinCntW = 32;
    localparam int QDepth = 2;
    localparam logic [0:0] RegShort = 1'b0;
    localparam logic [0:0] RegLong  = 1'b1;

    typedef struct packed {
        logic [RateW-1:0] rate;
        logic [TimeW-1:0] time_ms;
        logic [BinW-1:0]  bin;
    } t_item;

    function automatic logic [BinW-1:0] bin_of(input logic [RateW-1:0] r);
        logic [BinW-1:0] b;
        b = 4'd0;
        if (r >= 10'd120) b = 4'd15;
        else if (r < 10'd5)  b = 4'd0;
        else if (r < 10'd10) b = 4'd1;
        else if (r < 10'd15) b = 4'd2;
        else if (r < 10'd20) b = 4'd3;
        else if (r < 10'd25) b = 4'd4;
        else if (r < 10'd30) b = 4'd5;
        else if (r < 10'd40) b = 4'd6;
        else if (r < 10'd50) b = 4'd7;
        else if (r < 10'd60) b = 4'd8;
        else if (r < 10'd70) b = 4'd9;
        else if (r < 10'd80) b = 4'd10;
        else if (r < 10'd90) b = 4'd11;
        else if (r < 10'd100) b = 4'd12;
        else if (r < 10'd110) b = 4'd13;
        else b = 4'd14;
        return b;
    endfunction
endpackage
`default_nettype wire

>>> rtl/frwm_ram.sv
`default_nettype none
module frwm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/frwm_front.sv
`default_nettype none
module frwm_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [frwm_pkg::RateW-1:0] i_rate,
    input  wire logic [frwm_pkg::TimeW-1:0] i_time,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output frwm_pkg::t_item                 o_item
);
    frwm_pkg::t_item r_q [frwm_pkg::QDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;
    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_q[r_wp].rate    <= i_rate;
            r_q[r_wp].time_ms <= i_time;
            r_q[r_wp].bin     <= frwm_pkg::bin_of(i_rate);
        end
    end
endmodule
`default_nettype wire

>>> rtl/frwm_window.sv
`default_nettype none
// One time window: push (dropping the head first when full), evict one head per step, then bit-serial divide.
module frwm_window (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [frwm_pkg::RateW-1:0] i_rate,
    input  wire logic [frwm_pkg::TimeW-1:0] i_time,
    input  wire logic [15:0]                i_len,
    output logic                            o_done,
    output logic [frwm_pkg::RateW-1:0]      o_avg
);
    typedef enum logic [2:0] {S_IDLE, S_POP, S_PUSH, S_RD, S_WAIT, S_CHK, S_DIV}
        t_state;
    t_state r_state;
    logic [frwm_pkg::PtrW-1:0] r_head, r_tail;
    logic [frwm_pkg::CntW-1:0] r_count;
    logic [frwm_pkg::SumW-1:0] r_sum, r_rem;
    logic [frwm_pkg::RateW-1:0] r_quo;
    logic [4:0] r_bit;
    logic [frwm_pkg::EntW-1:0] rdata;
    logic we;
    logic [frwm_pkg::TimeW-1:0] diff;
    logic [frwm_pkg::SumW:0] shifted;
    logic [frwm_pkg::SumW:0] trial;

    assign we = (r_state == S_PUSH);
    frwm_ram #(.Width(frwm_pkg::EntW), .Depth(frwm_pkg::WindowDepth)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_tail),
        .i_wdata({i_rate, i_time}), .i_raddr(r_head), .o_rdata(rdata));

    assign diff    = i_time - rdata[frwm_pkg::TimeW-1:0];
    // bring down the next dividend bit, then try the subtract
    assign shifted = {r_rem, r_sum[r_bit - 5'd1]};
    assign trial   = shifted - {1'b0, {(frwm_pkg::SumW-frwm_pkg::CntW){1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= '0;
            r_tail <= '0;
            r_count <= '0;
            r_sum <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_state <= (r_count == frwm_pkg::CntW'(frwm_pkg::WindowDepth))
                               ? S_WAIT : S_PUSH;
                end
                S_PUSH: begin
                    r_tail <= r_tail + 1'b1;
                    r_count <= r_count + 1'b1;
                    r_sum <= r_sum + frwm_pkg::SumW'(i_rate);
                    r_state <= S_RD;
                end
                S_RD: r_state <= S_CHK;
                // full case: rdata is the head, drop it then push
                S_WAIT: r_state <= S_POP;
                S_POP: begin
                    r_sum <= r_sum - frwm_pkg::SumW'(rdata[frwm_pkg::EntW-1:frwm_pkg::TimeW]);
                    r_head <= r_head + 1'b1;
                    r_count <= r_count - 1'b1;
                    r_state <= S_PUSH;
                end
                S_CHK: begin
                    if (r_count > 1 && diff >= frwm_pkg::TimeW'(i_len)) begin
                        r_sum <= r_sum - frwm_pkg::SumW'(rdata[frwm_pkg::EntW-1:frwm_pkg::TimeW]);
                        r_head <= r_head + 1'b1;
                        r_count <= r_count - 1'b1;
                        r_state <= S_RD;
                    end else begin
                        r_rem <= '0;
                        r_quo <= '0;
                        r_bit <= 5'(frwm_pkg::SumW);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_bit == 5'd0) begin
                        o_avg <= r_quo;
                        o_done <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                        if (!trial[frwm_pkg::SumW]) begin
                            r_rem <= trial[frwm_pkg::SumW-1:0];
                            r_quo <= {r_quo[frwm_pkg::RateW-2:0], 1'b1};
                        end else begin
                            r_rem <= shifted[frwm_pkg::SumW-1:0];
                            r_quo <= {r_quo[frwm_pkg::RateW-2:0], 1'b0};
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/frwm_back.sv
`default_nettype none
module frwm_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  frwm_pkg::t_item  i_item,
    input  wire logic [15:0] i_short_len,
    input  wire logic [15:0] i_long_len,
    output logic             o_tvalid,
    input  wire logic        i_tready,
    output logic [55:0]      o_tdata
);
    typedef enum logic [1:0] {B_IDLE, B_RUN, B_OUT} t_state;
    t_state r_state;
    frwm_pkg::t_item r_it;
    logic r_start, r_sd, r_ld;
    logic [frwm_pkg::RateW-1:0] r_sa, r_la;
    logic sd, ld;
    logic [frwm_pkg::RateW-1:0] sa, la;
    logic [frwm_pkg::BinCntW-1:0] r_bins [16];
    logic [frwm_pkg::BinCntW-1:0] cur;

    assign o_ready = (r_state == B_IDLE);
    assign cur = r_bins[r_it.bin];

    frwm_window u_s (.i_clk, .i_rst_n, .i_start(r_start), .i_rate(r_it.rate),
        .i_time(r_it.time_ms), .i_len(i_short_len), .o_done(sd), .o_avg(sa));
    frwm_window u_l (.i_clk, .i_rst_n, .i_start(r_start), .i_rate(r_it.rate),
        .i_time(r_it.time_ms), .i_len(i_long_len), .o_done(ld), .o_avg(la));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_start <= 1'b0;
            o_tvalid <= 1'b0;
            r_sd <= 1'b0;
            r_ld <= 1'b0;
            for (int i = 0; i < 16; i++) r_bins[i] <= '0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                B_IDLE: if (i_valid) begin
                    r_it <= i_item;
                    r_start <= 1'b1;
                    r_sd <= 1'b0;
                    r_ld <= 1'b0;
                    r_state <= B_RUN;
                end
                B_RUN: begin
                    if (sd) begin r_sd <= 1'b1; r_sa <= sa; end
                    if (ld) begin r_ld <= 1'b1; r_la <= la; end
                    if ((r_sd || sd) && (r_ld || ld)) begin
                        if (cur != '1) r_bins[r_it.bin] <= cur + 1'b1;
                        o_tdata <= {((cur != '1) ? cur + 1'b1 : cur), r_it.bin,
                                    (ld ? la : r_la), (sd ? sa : r_sa)};
                        o_tvalid <= 1'b1;
                        r_state <= B_OUT;
                    end
                end
                B_OUT: if (i_tready) begin
                    o_tvalid <= 1'b0;
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/frame_rate_window_monitor.sv
// channel | dir | payload
// s_axis  | in  | tdata[9:0] frame_rate, [41:10] time_ms
// m_axis  | out | tdata[9:0] short_avg, [19:10] long_avg, [23:20] bin, [55:24] count
// cfg     | in  | index 0 short_window_ms, 1 long_window_ms
// Per item: a pop first when a window is full, a push, one RAM read and one
// check per evicted sample, then a bit-serial divide.
// Both windows run side by side; the slower one sets the time.
// Two-entry queue decouples input from processing; reset is synchronous.
// A stalled output holds the block; no memory clear is needed after reset.
`default_nettype none
module frame_rate_window_monitor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata, // frame_rate, time_ms
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata, // short_avg, long_avg, bin, count
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    logic [15:0] r_short, r_long;
    logic qv, qr;
    frwm_pkg::t_item qi;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short <= 16'd5000;
            r_long <= 16'd15000;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == frwm_pkg::RegShort) r_short <= i_cfg_data;
            if (i_cfg_index == frwm_pkg::RegLong) r_long <= i_cfg_data;
        end
    end
    frwm_front u_f (.i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_rate(s_axis_tdata[9:0]), .i_time(s_axis_tdata[41:10]),
        .o_valid(qv), .i_ready(qr), .o_item(qi));
    frwm_back u_b (.i_clk, .i_rst_n, .i_valid(qv), .o_ready(qr), .i_item(qi),
        .i_short_len(r_short), .i_long_len(r_long), .o_tvalid(m_axis_tvalid),
        .i_tready(m_axis_tready), .o_tdata(m_axis_tdata));
endmodule
`default_nettype wire

>>> rtl/frwm_checker.sv
`default_nettype none
module frwm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[55:24] != 32'd0)
        else $error("zero bin count");
    a_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("duplicate result");
endmodule
bind frame_rate_window_monitor frwm_checker u_chk (.i_clk, .i_rst_n, .m_axis_tvalid,
    .m_axis_tready, .m_axis_tdata);
`default_nettype wire
